// ===== sv/etp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the exclusive-time profiler.
// No dependencies.
package etp_pkg;

   localparam int ID_W   = 4;
   localparam int TIME_W = 32;
   localparam int MODE_W = 2;
   localparam int STAT_W = 2;

   // request modes
   localparam logic [MODE_W-1:0] MODE_START = 2'd0;
   localparam logic [MODE_W-1:0] MODE_END   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   // response status
   localparam logic [STAT_W-1:0] STAT_APPLIED = 2'd0;
   localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd1;
   localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd2;
   localparam logic [STAT_W-1:0] STAT_READ    = 2'd3;

   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   // one call-stack entry
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] start;
   } etp_entry_type;

   // shift control broadcast to every stack cell
   typedef struct packed {
      logic push;
      logic pop;
   } etp_shift_type;

endpackage

// ===== sv/etp_stack_cell.sv =====
`timescale 1ns / 1ps
// One level of the shifting call stack.
// Depends on etp_pkg.
module etp_stack_cell (
   input  logic                   clock,
   input  etp_pkg::etp_shift_type shift,
   input  etp_pkg::etp_entry_type from_above,
   input  etp_pkg::etp_entry_type from_below,
   output etp_pkg::etp_entry_type entry
);
   import etp_pkg::*;

   etp_entry_type entry_ff;
   etp_entry_type entry_in;

   always_comb begin
      priority if (shift.push) begin
         entry_in = from_above;
      end else if (shift.pop) begin
         entry_in = from_below;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== sv/etp_accum_bank.sv =====
`timescale 1ns / 1ps
// Per-function accumulator memory with per-entry valid bits (reads zero until written).
// Depends on etp_pkg.
module etp_accum_bank #(
   parameter int NUM_FUNCS = 16,
   parameter int ADDR_W    = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [etp_pkg::TIME_W-1:0] rd_data,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [etp_pkg::TIME_W-1:0] wr_data
);
   import etp_pkg::*;

   logic [TIME_W-1:0]    mem [NUM_FUNCS];
   logic [NUM_FUNCS-1:0] vld_ff;
   logic [TIME_W-1:0]    rd_data_ff;
   logic                 rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ===== sv/exclusive_time_profiler_core.sv =====
`timescale 1ns / 1ps
// Exclusive-time profiler core: call stack as a chain of shifting cells, accumulators in RAM.
// A request runs through RDA, UPD and RDB to RSP, which loads the response register
// once it is free; req_stall is high until then, set by the single read port of the RAM
//   (read-modify-write of the credited id, then a re-read of the request's id).
// Reset (synchronous): stack empty, all accumulators read as zero, no response pending.
module exclusive_time_profiler_core #(
   parameter int NUM_FUNCS   = 16,
   parameter int STACK_DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [etp_pkg::MODE_W-1:0] req_mode,
   input  logic [etp_pkg::ID_W-1:0]   req_func_id,
   input  logic [etp_pkg::TIME_W-1:0] req_timestamp,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [etp_pkg::STAT_W-1:0] rsp_status,
   output logic [etp_pkg::ID_W-1:0]   rsp_reply_id,
   output logic [etp_pkg::TIME_W-1:0] rsp_total_time
);
   import etp_pkg::*;

   localparam int FA_W = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
   localparam int LV_W = $clog2(STACK_DEPTH + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;  // wait for a request
   localparam logic [2:0] S_RDA  = 3'd1;  // read accumulator to be credited
   localparam logic [2:0] S_UPD  = 3'd2;  // saturating add, write back
   localparam logic [2:0] S_RDB  = 3'd3;  // read accumulator of the request's id
   localparam logic [2:0] S_RSP  = 3'd4;  // load response register

   logic [2:0]        state_ff, state_in;
   logic [LV_W-1:0]   level_ff, level_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // per-request context, captured at accept
   logic [STAT_W-1:0] status_ff;
   logic [ID_W-1:0]   id_ff;
   logic              in_range_ff;
   logic [FA_W-1:0]   fn_addr_ff;
   logic              cr_do_ff;
   logic [FA_W-1:0]   cr_addr_ff;
   logic [TIME_W:0]   cr_amt_ff;

   logic [STAT_W-1:0] rsp_status_ff;
   logic [ID_W-1:0]   rsp_reply_id_ff;
   logic [TIME_W-1:0] rsp_total_time_ff;

   logic              accept;
   logic              stack_full;
   logic              stack_empty;
   etp_shift_type     shift;
   etp_entry_type     top;
   etp_entry_type     new_entry;
   etp_entry_type     cell_q [STACK_DEPTH];
   etp_entry_type     restart_entry;
   logic [TIME_W-1:0] restart_ts;
   logic [TIME_W-1:0] elapsed;
   logic              req_in_range;
   logic              top_in_range;
   logic [FA_W-1:0]   req_addr;
   logic [FA_W-1:0]   top_addr;
   logic [ID_W+FA_W-1:0] req_ext;
   logic [ID_W+FA_W-1:0] top_ext;
   logic [STAT_W-1:0] status_new;
   logic              cr_do_new;
   logic [FA_W-1:0]   cr_addr_new;
   logic [TIME_W:0]   cr_amt_new;

   logic [FA_W-1:0]   bank_rd_addr;
   logic [TIME_W-1:0] bank_rd_data;
   logic              bank_wr_en;
   logic [TIME_W+1:0] sum;
   logic [TIME_W-1:0] sum_sat;

   //------------------------------------------------------------------
   // Request decode
   //------------------------------------------------------------------
   assign req_stall   = (state_ff != S_IDLE);
   assign accept      = req_valid && !req_stall;
   assign stack_full  = (level_ff == LV_W'(STACK_DEPTH));
   assign stack_empty = (level_ff == '0);
   assign top         = cell_q[0];

   // ids map onto RAM addresses; ids at or beyond NUM_FUNCS never write the RAM and report zero
   assign req_ext      = {{FA_W{1'b0}}, req_func_id};
   assign top_ext      = {{FA_W{1'b0}}, top.id};
   assign req_addr     = req_ext[FA_W-1:0];
   assign top_addr     = top_ext[FA_W-1:0];
   assign req_in_range = (32'(req_func_id) < 32'(NUM_FUNCS));
   assign top_in_range = (32'(top.id) < 32'(NUM_FUNCS));

   // time run by the current top; a timestamp behind its start counts as zero
   assign elapsed = (req_timestamp >= top.start) ? (req_timestamp - top.start) : '0;

   always_comb begin
      status_new  = STAT_READ;
      cr_do_new   = 1'b0;
      cr_addr_new = top_addr;
      cr_amt_new  = {1'b0, elapsed};
      shift       = '0;
      unique case (req_mode)
         MODE_START: begin
            if (stack_full) begin
               status_new = STAT_REFUSED;
            end else begin
               status_new = STAT_APPLIED;
               cr_do_new  = !stack_empty && top_in_range;  // charge the caller
               shift.push = accept;
            end
         end
         MODE_END: begin
            cr_addr_new = req_addr;
            cr_amt_new  = {1'b0, elapsed} + (TIME_W+1)'(1);
            if (stack_empty) begin
               status_new = STAT_IGNORED;
            end else begin
               status_new = STAT_APPLIED;
               cr_do_new  = req_in_range;  // the end's own id, whatever is on top
               shift.pop  = accept;
            end
         end
         default: begin
            status_new = STAT_READ;  // read, and the unused fourth code
         end
      endcase
   end

   //------------------------------------------------------------------
   // Call stack: cell 0 is the top. Push moves every entry one cell down,
   // pop moves them up; the caller that becomes top restarts at time + 1, saturating at TIME_MAX.
   //------------------------------------------------------------------
   assign new_entry.id    = req_func_id;
   assign new_entry.start = req_timestamp;
   assign restart_ts      = (req_timestamp == TIME_MAX) ? TIME_MAX
                                                        : req_timestamp + TIME_W'(1);

   generate
      if (STACK_DEPTH > 1) begin : g_restart_deep
         assign restart_entry.id = cell_q[1].id;
      end else begin : g_restart_one
         assign restart_entry.id = '0;
      end
   endgenerate
   assign restart_entry.start = restart_ts;

   genvar gi;
   generate
      for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
         etp_entry_type above;
         etp_entry_type below;
         if (gi == 0) begin : g_top
            assign above = new_entry;
            assign below = restart_entry;
         end else if (gi == STACK_DEPTH - 1) begin : g_bottom
            assign above = cell_q[gi-1];
            assign below = '0;
         end else begin : g_mid
            assign above = cell_q[gi-1];
            assign below = cell_q[gi+1];
         end
         etp_stack_cell u_cell (
            .clock      (clock),
            .shift      (shift),
            .from_above (above),
            .from_below (below),
            .entry      (cell_q[gi])
         );
      end
   endgenerate

   //------------------------------------------------------------------
   // Accumulator RAM
   //------------------------------------------------------------------
   assign bank_rd_addr = (state_ff == S_RDA) ? cr_addr_ff : fn_addr_ff;
   assign bank_wr_en   = (state_ff == S_UPD) && cr_do_ff;
   assign sum          = {2'b00, bank_rd_data} + {1'b0, cr_amt_ff};
   assign sum_sat      = (sum[TIME_W+1:TIME_W] != 2'b00) ? TIME_MAX : sum[TIME_W-1:0];

   etp_accum_bank #(
      .NUM_FUNCS (NUM_FUNCS),
      .ADDR_W    (FA_W)
   ) u_bank (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (bank_rd_addr),
      .rd_data (bank_rd_data),
      .wr_en   (bank_wr_en),
      .wr_addr (cr_addr_ff),
      .wr_data (sum_sat)
   );

   //------------------------------------------------------------------
   // Sequencer and response register
   //------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (shift.push) begin
         level_in = level_ff + LV_W'(1);
      end else if (shift.pop) begin
         level_in = level_ff - LV_W'(1);
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_RDA;
            end
         end
         S_RDA: state_in = S_UPD;
         S_UPD: state_in = S_RDB;
         S_RDB: state_in = S_RSP;
         S_RSP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff   <= status_new;
         id_ff       <= req_func_id;
         in_range_ff <= req_in_range;
         fn_addr_ff  <= req_addr;
         cr_do_ff    <= cr_do_new;
         cr_addr_ff  <= cr_addr_new;
         cr_amt_ff   <= cr_amt_new;
      end
      if ((state_ff == S_RSP) && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_status_ff     <= status_ff;
         rsp_reply_id_ff   <= id_ff;
         rsp_total_time_ff <= in_range_ff ? bank_rd_data : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_reply_id   = rsp_reply_id_ff;
   assign rsp_total_time = rsp_total_time_ff;

   //------------------------------------------------------------------
   // Assertions
   //------------------------------------------------------------------
   a_level_bound : assert property (@(posedge clock) disable iff (reset)
      level_ff <= LV_W'(STACK_DEPTH))
      else $error("stack level beyond depth");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("request taken while previous one in flight");

   a_read_keeps_stack : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_mode != MODE_START) && (req_mode != MODE_END)) |=> $stable(level_ff))
      else $error("read request changed the stack");

   a_refused_stays_full : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_mode == MODE_START) && stack_full) |=> stack_full)
      else $error("refused start changed the stack");

   a_wb_only_in_update : assert property (@(posedge clock) disable iff (reset)
      bank_wr_en |-> ($past(state_ff) == S_RDA))
      else $error("accumulator write without preceding read");

endmodule
